FILE: rtl/hufd_pkg.sv
// ----------------------------------------------------------------------------
// hufd_pkg: shared types and constants of the Huffman tree-walk decoder
// Field layout of the stream words, node entry type and status codes.
// ----------------------------------------------------------------------------
package hufd_pkg;

  // Default tree size (nodes)
  localparam int MAX_NODES_DFLT = 512;

  // Input item field widths
  localparam int NODE_IDX_W = 9;
  localparam int CHILD_W    = 10;
  localparam int LEAF_SYM_W = 9;
  localparam int BYTE_W     = 8;
  localparam int BITS_W     = 4;

  // Input tdata bit offsets, lowest field first
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_LEFT_LSB  = IN_IDX_LSB + NODE_IDX_W;
  localparam int IN_RIGHT_LSB = IN_LEFT_LSB + CHILD_W;
  localparam int IN_SYM_LSB   = IN_RIGHT_LSB + CHILD_W;
  localparam int IN_BYTE_LSB  = IN_SYM_LSB + LEAF_SYM_W;
  localparam int IN_BITS_LSB  = IN_BYTE_LSB + BYTE_W;
  localparam int IN_USED_W    = IN_BITS_LSB + BITS_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Result field widths and tdata layout
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 2;
  localparam int OUT_USED_W  = SYM_W + CODE_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration register width
  localparam int COUNT_W = 24;

  // Most bits used from one byte
  localparam logic [BITS_W-1:0] BITS_MAX = BITS_W'(8);

  // Item kinds carried on in_tuser
  localparam logic FUNC_NODE = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // End-of-stream status codes
  localparam logic [CODE_W-1:0] ST_OK       = 2'd0;
  localparam logic [CODE_W-1:0] ST_BAD_CODE = 2'd1;
  localparam logic [CODE_W-1:0] ST_TOO_MANY = 2'd2;
  localparam logic [CODE_W-1:0] ST_TOO_FEW  = 2'd3;

  // One tree node: children (sign bit set = none) and leaf symbol
  // (sign bit set = internal node)
  typedef struct packed {
    logic [CHILD_W-1:0]    left;
    logic [CHILD_W-1:0]    right;
    logic [LEAF_SYM_W-1:0] sym;
  } node_t;

endpackage

FILE: rtl/hufd_node_mem.sv
// ----------------------------------------------------------------------------
// hufd_node_mem: code tree node store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hufd_node_mem #(
  parameter int DEPTH = hufd_pkg::MAX_NODES_DFLT
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  hufd_pkg::node_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output hufd_pkg::node_t            rd_data
);

  hufd_pkg::node_t mem [DEPTH];
  hufd_pkg::node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/huffman_trie_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_trie_decoder_unit: bit-serial Huffman code tree walker
// Loads a code tree node by node and decodes bitstream bytes against it.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Payload
// -------  ---------  --------------------------------------------------------
// in_      slave      tuser: func; tdata: node_index, left_child, right_child,
//                     leaf_symbol, data_byte, bits_in_byte; tlast: last_byte
// out_     master     tuser: is_status; tdata: symbol, status_code;
//                     tlast: last result of a request
// cfg_     write-only expected_symbol_count
//
// A node write request is taken in S_IDLE. A data request is accepted in
// S_IDLE and the current node is read in S_FETCH; each bit then passes S_STEP
// and S_LEAF, and a bit that completes a symbol passes S_FETCH again if bits
// remain (the node memory's registered read port is visited once or twice
// per bit); the held symbol and any status result then drain in S_END.
// in_tready is high only while the walker is idle. A stalled result holds
// the walker in place; the output register lets one result wait while the
// next is formed. Reset (synchronous, rst_n low) returns the walk to the
// root and clears the symbol count, the failure code and the register; the
// node memory is not cleared.
//
module huffman_trie_decoder_unit #(
  parameter int MAX_NODES = hufd_pkg::MAX_NODES_DFLT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input requests
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [8:0] node_index, [18:9] left_child, [28:19] right_child,
  // [37:29] leaf_symbol, [45:38] data_byte, [49:46] bits_in_byte, rest zero
  input  logic [hufd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] func
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] symbol, [9:8] status_code, rest zero
  output logic [hufd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] is_status
  output logic                                out_tuser,
  output logic                                out_tlast,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [hufd_pkg::COUNT_W-1:0]        cfg_wr_data
);

  localparam int AW = $clog2(MAX_NODES);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;  // read current node
  localparam logic [2:0] S_STEP  = 3'd2;  // follow one bit, read child
  localparam logic [2:0] S_LEAF  = 3'd3;  // inspect child symbol
  localparam logic [2:0] S_END   = 3'd4;  // drain held symbol / status

  // Input field unpack
  logic [hufd_pkg::NODE_IDX_W-1:0] in_idx;
  logic [hufd_pkg::CHILD_W-1:0]    in_left;
  logic [hufd_pkg::CHILD_W-1:0]    in_right;
  logic [hufd_pkg::LEAF_SYM_W-1:0] in_sym;
  logic [hufd_pkg::BYTE_W-1:0]     in_byte;
  logic [hufd_pkg::BITS_W-1:0]     in_bits;

  assign in_idx   = in_tdata[hufd_pkg::IN_IDX_LSB   +: hufd_pkg::NODE_IDX_W];
  assign in_left  = in_tdata[hufd_pkg::IN_LEFT_LSB  +: hufd_pkg::CHILD_W];
  assign in_right = in_tdata[hufd_pkg::IN_RIGHT_LSB +: hufd_pkg::CHILD_W];
  assign in_sym   = in_tdata[hufd_pkg::IN_SYM_LSB   +: hufd_pkg::LEAF_SYM_W];
  assign in_byte  = in_tdata[hufd_pkg::IN_BYTE_LSB  +: hufd_pkg::BYTE_W];
  assign in_bits  = in_tdata[hufd_pkg::IN_BITS_LSB  +: hufd_pkg::BITS_W];

  // Registers
  logic [2:0]                      state_r, state_nxt;
  logic [AW-1:0]                   cur_node_r, cur_node_nxt;
  logic [hufd_pkg::COUNT_W-1:0]    sym_cnt_r, sym_cnt_nxt;
  logic [hufd_pkg::COUNT_W-1:0]    exp_cnt_r;
  logic [hufd_pkg::CODE_W-1:0]     fail_r, fail_nxt;
  logic [hufd_pkg::BYTE_W-1:0]     byte_r, byte_nxt;
  logic [hufd_pkg::BITS_W-1:0]     bits_left_r, bits_left_nxt;
  logic                            final_r, final_nxt;
  logic                            pend_vld_r, pend_vld_nxt;
  logic [hufd_pkg::SYM_W-1:0]      pend_sym_r, pend_sym_nxt;

  logic                            out_vld_r;
  logic [hufd_pkg::SYM_W-1:0]      out_sym_r;
  logic                            out_stat_r;
  logic [hufd_pkg::CODE_W-1:0]     out_code_r;
  logic                            out_last_r;

  // Result push into the output register
  logic                            can_push;
  logic                            push;
  logic [hufd_pkg::SYM_W-1:0]      push_sym;
  logic                            push_stat;
  logic [hufd_pkg::CODE_W-1:0]     push_code;
  logic                            push_last;

  // Node memory access
  logic                            mem_wr_en;
  logic [AW-1:0]                   mem_wr_addr;
  hufd_pkg::node_t                 mem_wr_data;
  logic                            mem_rd_en;
  logic [AW-1:0]                   mem_rd_addr;
  hufd_pkg::node_t                 node;

  // Walk helpers
  logic [hufd_pkg::CHILD_W-1:0]    child;
  logic [31:0]                     child_ext;
  logic                            child_ok;
  logic [31:0]                     idx_ext;
  logic                            idx_ok;
  logic [hufd_pkg::CODE_W-1:0]     end_code;

  assign in_tready = (state_r == S_IDLE);
  assign can_push  = !out_vld_r || out_tready;

  assign idx_ext = 32'(in_idx);
  assign idx_ok  = (idx_ext < 32'(MAX_NODES));

  assign mem_wr_addr = idx_ext[AW-1:0];
  assign mem_wr_data = '{left: in_left, right: in_right, sym: in_sym};

  // Child of the current node for the bit at the head of the byte
  assign child     = byte_r[hufd_pkg::BYTE_W-1] ? node.right : node.left;
  assign child_ext = 32'(child);
  assign child_ok  = !child[hufd_pkg::CHILD_W-1] && (child_ext < 32'(MAX_NODES));

  assign end_code = (fail_r != hufd_pkg::ST_OK) ? fail_r :
                    (sym_cnt_r != exp_cnt_r)    ? hufd_pkg::ST_TOO_FEW :
                                                  hufd_pkg::ST_OK;

  hufd_node_mem #(
    .DEPTH (MAX_NODES)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (node)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_node_nxt  = cur_node_r;
    sym_cnt_nxt   = sym_cnt_r;
    fail_nxt      = fail_r;
    byte_nxt      = byte_r;
    bits_left_nxt = bits_left_r;
    final_nxt     = final_r;
    pend_vld_nxt  = pend_vld_r;
    pend_sym_nxt  = pend_sym_r;
    push          = 1'b0;
    push_sym      = pend_sym_r;
    push_stat     = 1'b0;
    push_code     = hufd_pkg::ST_OK;
    push_last     = 1'b0;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = cur_node_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == hufd_pkg::FUNC_NODE) begin
            // drop writes beyond the tree
            mem_wr_en = idx_ok;
          end else begin
            byte_nxt      = in_byte;
            bits_left_nxt = (in_bits > hufd_pkg::BITS_MAX) ? hufd_pkg::BITS_MAX : in_bits;
            final_nxt     = in_tlast;
            if ((fail_r != hufd_pkg::ST_OK) || (in_bits == '0)) begin
              state_nxt = S_END;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        end
      end

      S_FETCH: begin
        mem_rd_en = 1'b1;
        state_nxt = S_STEP;
      end

      S_STEP: begin
        // consume the head bit
        byte_nxt      = byte_r << 1;
        bits_left_nxt = bits_left_r - 1'b1;
        if (!child_ok) begin
          fail_nxt  = hufd_pkg::ST_BAD_CODE;
          state_nxt = S_END;
        end else begin
          cur_node_nxt = child_ext[AW-1:0];
          mem_rd_en    = 1'b1;
          mem_rd_addr  = child_ext[AW-1:0];
          state_nxt    = S_LEAF;
        end
      end

      S_LEAF: begin
        if (node.sym[hufd_pkg::LEAF_SYM_W-1]) begin
          // internal node: its entry is already in the read register
          state_nxt = (bits_left_r == '0) ? S_END : S_STEP;
        end else if (sym_cnt_r >= exp_cnt_r) begin
          fail_nxt  = hufd_pkg::ST_TOO_MANY;
          state_nxt = S_END;
        end else if (!pend_vld_r || can_push) begin
          // release the held symbol, hold the new one
          push         = pend_vld_r;
          pend_vld_nxt = 1'b1;
          pend_sym_nxt = node.sym[hufd_pkg::SYM_W-1:0];
          sym_cnt_nxt  = sym_cnt_r + 1'b1;
          cur_node_nxt = '0;
          state_nxt    = (bits_left_r == '0) ? S_END : S_FETCH;
        end
      end

      S_END: begin
        if (pend_vld_r) begin
          if (can_push) begin
            push         = 1'b1;
            push_last    = !final_r;
            pend_vld_nxt = 1'b0;
            if (!final_r) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (final_r) begin
          if (can_push) begin
            push         = 1'b1;
            push_sym     = '0;
            push_stat    = 1'b1;
            push_code    = end_code;
            push_last    = 1'b1;
            cur_node_nxt = '0;
            sym_cnt_nxt  = '0;
            fail_nxt     = hufd_pkg::ST_OK;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_node_r <= '0;
      sym_cnt_r  <= '0;
      fail_r     <= hufd_pkg::ST_OK;
      pend_vld_r <= 1'b0;
      exp_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_node_r <= cur_node_nxt;
      sym_cnt_r  <= sym_cnt_nxt;
      fail_r     <= fail_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_wr_en) begin
        exp_cnt_r <= cfg_wr_data;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    bits_left_r <= bits_left_nxt;
    final_r     <= final_nxt;
    pend_sym_r  <= pend_sym_nxt;
    if (push) begin
      out_sym_r  <= push_sym;
      out_stat_r <= push_stat;
      out_code_r <= push_code;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(hufd_pkg::OUT_TDATA_W - hufd_pkg::OUT_USED_W)'(0),
                       out_code_r, out_sym_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Huffman tree-walk decoder
// Loads code trees, sends encoded and corrupted bitstreams through the
// stream ports and checks every symbol and status result against a local
// model of the tree walk.
// ----------------------------------------------------------------------------
module tb;
  import hufd_pkg::*;

  localparam int NODES         = MAX_NODES_DFLT;
  // Time allowed for a full byte to finish its walk and drain its results.
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_SLOTS     = 32;

  // A request as the bench sees it, unpacked by field
  typedef struct {
    logic                  func;
    logic [NODE_IDX_W-1:0] idx;
    logic [CHILD_W-1:0]    lch;
    logic [CHILD_W-1:0]    rch;
    logic [LEAF_SYM_W-1:0] leaf;
    logic [BYTE_W-1:0]     dbyte;
    logic [BITS_W-1:0]     nbits;
    logic                  fin;
  } hufd_req_t;

  // One result, in the order the fields are compared
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic              is_status;
    logic [CODE_W-1:0] code;
    logic              last;
  } hufd_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]     cfg_wr_data = '0;

  always #10 clk = ~clk;

  huffman_trie_decoder_unit #(.MAX_NODES(NODES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Decoder model state: the node tables, the walk position, the running
  // symbol count, the sticky failure code and the expected count register.
  // --------------------------------------------------------------------------
  logic [CHILD_W-1:0]    tree_left  [NODES];
  logic [CHILD_W-1:0]    tree_right [NODES];
  logic [LEAF_SYM_W-1:0] tree_sym   [NODES];
  logic [NODE_IDX_W-1:0] walk_node     = '0;
  logic [COUNT_W-1:0]    decoded_count = '0;
  logic [CODE_W-1:0]     fail_code     = ST_OK;
  logic [COUNT_W-1:0]    want_count    = '0;

  // Results still owed by the block, oldest first
  hufd_res_t decoded_fifo[$];

  // Idle rates in percent for the sender and the receiver
  int gap_pct   = 28;
  int stall_pct = 76;

  int requests_sent  = 0;
  int results_seen   = 0;
  int symbols_seen   = 0;
  int err_count      = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  // Code tree under test: slot 0 is the root, children always sit in
  // higher slots than their parent so a reverse sweep writes children first.
  int          tr_id   [MAX_SLOTS];
  int          tr_lslot[MAX_SLOTS];
  int          tr_rslot[MAX_SLOTS];
  int          tr_sym  [MAX_SLOTS];
  int          tr_len  [MAX_SLOTS];
  logic [15:0] tr_code [MAX_SLOTS];
  bit          tr_leaf [MAX_SLOTS];
  bit          tr_drop [MAX_SLOTS];
  int          tr_n = 0;
  bit          tree_dirty = 1'b1;

  // --------------------------------------------------------------------------
  // Tree walk model: apply one accepted request and queue its results.
  // --------------------------------------------------------------------------
  task automatic walk_tree(input hufd_req_t rq);
    hufd_res_t          produced[$];
    hufd_res_t          r;
    int                 nb;
    logic               bitv;
    logic [CHILD_W-1:0] nxt;
    logic [CODE_W-1:0]  st;
    if (rq.func == FUNC_NODE) begin
      tree_left[rq.idx]  = rq.lch;
      tree_right[rq.idx] = rq.rch;
      tree_sym[rq.idx]   = rq.leaf;
      return;
    end
    // Clamp oversized bit counts to a full byte.
    nb = (rq.nbits > BITS_MAX) ? int'(BITS_MAX) : int'(rq.nbits);
    for (int i = 0; i < nb; i++) begin
      // A failed stream ignores every further bit until its final byte.
      if (fail_code != ST_OK) break;
      bitv = rq.dbyte[BYTE_W-1-i];
      nxt  = bitv ? tree_right[walk_node] : tree_left[walk_node];
      if (nxt[CHILD_W-1]) begin
        fail_code = ST_BAD_CODE;
      end else begin
        walk_node = nxt[NODE_IDX_W-1:0];
        // Sign bit of the symbol marks an internal node: keep walking.
        if (!tree_sym[walk_node][LEAF_SYM_W-1]) begin
          if (decoded_count >= want_count) begin
            fail_code = ST_TOO_MANY;
          end else begin
            r.sym       = tree_sym[walk_node][SYM_W-1:0];
            r.is_status = 1'b0;
            r.code      = ST_OK;
            r.last      = 1'b0;
            produced.push_back(r);
            decoded_count = decoded_count + 1'b1;
            walk_node     = '0;
          end
        end
      end
    end
    if (rq.fin) begin
      st = fail_code;
      if (st == ST_OK && decoded_count != want_count) st = ST_TOO_FEW;
      r.sym       = '0;
      r.is_status = 1'b1;
      r.code      = st;
      r.last      = 1'b0;
      produced.push_back(r);
      walk_node     = '0;
      decoded_count = '0;
      fail_code     = ST_OK;
    end
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[k]) decoded_fifo.push_back(produced[k]);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest one owed.
  // --------------------------------------------------------------------------
  hufd_res_t got_res;
  hufd_res_t exp_res;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.sym       = out_tdata[SYM_W-1:0];
      got_res.code      = out_tdata[SYM_W +: CODE_W];
      got_res.is_status = out_tuser;
      got_res.last      = out_tlast;
      results_seen++;
      if (decoded_fifo.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result sym %0d status %0b code %0d last %0b",
                 $time, got_res.sym, got_res.is_status, got_res.code, got_res.last);
      end else begin
        exp_res = decoded_fifo.pop_front();
        if (exp_res.is_status) status_tally[exp_res.code]++;
        else symbols_seen++;
        // Padding bits above the used fields must read as zero too.
        if (got_res !== exp_res || out_tdata[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
          err_count++;
          if (err_count <= 30)
            $display({"%0t: mismatch: expected sym %0d status %0b code %0d last %0b,",
                      " actual sym %0d status %0b code %0d last %0b (tdata %h)"},
                     $time, exp_res.sym, exp_res.is_status, exp_res.code, exp_res.last,
                     got_res.sym, got_res.is_status, got_res.code, got_res.last,
                     out_tdata);
        end
      end
    end
  end

  // Receiver back-pressure: drop tready at the current stall rate.
  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  // --------------------------------------------------------------------------
  // Request helpers
  // --------------------------------------------------------------------------
  // Build a node write; the data fields carry random noise.
  function automatic hufd_req_t node_req(input int idx, input int l, input int r,
                                         input int s);
    hufd_req_t rq;
    rq.func  = FUNC_NODE;
    rq.idx   = NODE_IDX_W'(idx);
    rq.lch   = CHILD_W'(l);
    rq.rch   = CHILD_W'(r);
    rq.leaf  = LEAF_SYM_W'(s);
    rq.dbyte = BYTE_W'($urandom);
    rq.nbits = BITS_W'($urandom);
    rq.fin   = 1'($urandom);
    return rq;
  endfunction

  // Build a data byte; the node fields carry random noise.
  function automatic hufd_req_t data_req(input int b, input int n, input bit fin);
    hufd_req_t rq;
    rq.func  = FUNC_DATA;
    rq.idx   = NODE_IDX_W'($urandom);
    rq.lch   = CHILD_W'($urandom);
    rq.rch   = CHILD_W'($urandom);
    rq.leaf  = LEAF_SYM_W'($urandom);
    rq.dbyte = BYTE_W'(b);
    rq.nbits = BITS_W'(n);
    rq.fin   = fin;
    return rq;
  endfunction

  // Send one request: idle for a random gap, hold it until accepted, then
  // apply it to the model. Leave tvalid high so the next request can follow
  // back to back.
  task automatic send_request(input hufd_req_t rq);
    logic [IN_TDATA_W-1:0] word;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word[IN_IDX_LSB   +: NODE_IDX_W] = rq.idx;
    word[IN_LEFT_LSB  +: CHILD_W]    = rq.lch;
    word[IN_RIGHT_LSB +: CHILD_W]    = rq.rch;
    word[IN_SYM_LSB   +: LEAF_SYM_W] = rq.leaf;
    word[IN_BYTE_LSB  +: BYTE_W]     = rq.dbyte;
    word[IN_BITS_LSB  +: BITS_W]     = rq.nbits;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= rq.func;
    in_tlast  <= rq.fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    walk_tree(rq);
    requests_sent++;
  endtask

  task automatic send_node(input int idx, input int l, input int r, input int s);
    send_request(node_req(idx, l, r, s));
  endtask

  task automatic send_data(input int b, input int n, input bit fin);
    send_request(data_req(b, n, fin));
  endtask

  // Drop tvalid, wait for every owed result, then let a byte that yields
  // no result finish its walk.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the expected symbol count; only done with the block idle.
  task automatic set_want_count(input int v);
    if (COUNT_W'(v) == want_count) return;
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    want_count   = COUNT_W'(v);
  endtask

  // --------------------------------------------------------------------------
  // Random code trees and bitstreams
  // --------------------------------------------------------------------------
  function automatic int child_ref(input int slot);
    return tr_drop[slot] ? -1 : tr_id[slot];
  endfunction

  // Grow a random full binary tree by splitting leaves, optionally prune one
  // leaf into a missing child, and write it bottom up.
  task automatic load_code_tree(input int leaves);
    int p, id, nl, d;
    bit clash;
    tr_n = 1;
    tr_id[0] = 0;  tr_leaf[0] = 1'b1;  tr_drop[0] = 1'b0;
    tr_len[0] = 0; tr_code[0] = '0;
    nl = 1;
    while (nl < leaves) begin
      do p = $urandom_range(0, tr_n - 1); while (!tr_leaf[p]);
      for (int c = 0; c < 2; c++) begin
        do begin
          id    = $urandom_range(1, NODES - 1);
          clash = 1'b0;
          for (int j = 0; j < tr_n; j++) if (tr_id[j] == id) clash = 1'b1;
        end while (clash);
        tr_id[tr_n]   = id;
        tr_leaf[tr_n] = 1'b1;
        tr_drop[tr_n] = 1'b0;
        tr_len[tr_n]  = tr_len[p] + 1;
        tr_code[tr_n] = {tr_code[p][14:0], c[0]};
        if (c == 0) tr_lslot[p] = tr_n;
        else tr_rslot[p] = tr_n;
        tr_n++;
      end
      tr_leaf[p] = 1'b0;
      nl++;
    end
    if (leaves > 2 && $urandom_range(0, 4) == 0) begin
      do d = $urandom_range(1, tr_n - 1); while (!tr_leaf[d]);
      tr_drop[d] = 1'b1;
    end
    for (int s = tr_n - 1; s >= 0; s--) begin
      if (tr_drop[s]) continue;
      if (tr_leaf[s]) begin
        // Children of a leaf are never followed: fill them with anything.
        tr_sym[s] = $urandom_range(0, 255);
        send_node(tr_id[s],
                  ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range(0, NODES - 1)),
                  ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range(0, NODES - 1)),
                  tr_sym[s]);
      end else begin
        send_node(tr_id[s], child_ref(tr_lslot[s]), child_ref(tr_rslot[s]), -1);
      end
    end
    tree_dirty = 1'b0;
  endtask

  // Pick a random node of the current tree that was actually written.
  function automatic int live_slot();
    int s;
    do s = $urandom_range(0, tr_n - 1); while (tr_drop[s]);
    return s;
  endfunction

  // One stream ending in a final byte. A clean stream encodes random symbols
  // with the current tree and sometimes corrupts it (count off by one,
  // flipped bit, trailing bits); a noisy one sends random bits and may
  // rewrite a tree node in the middle of the stream.
  task automatic send_stream(input bit noisy);
    bit              bits_q[$];
    int              k, s, want, n, pos;
    logic [BYTE_W-1:0] b;
    bit              fin;
    if (!noisy) begin
      k = $urandom_range(0, 10);
      want = k;
      repeat (k) begin
        do s = $urandom_range(0, tr_n - 1); while (!tr_leaf[s] || tr_drop[s]);
        for (int j = tr_len[s] - 1; j >= 0; j--) bits_q.push_back(tr_code[s][j]);
      end
      case ($urandom_range(0, 9))
        0: want = k + 1;
        1: if (k > 0) want = k - 1;
        2: if (bits_q.size() > 0) begin
             pos = $urandom_range(0, bits_q.size() - 1);
             bits_q[pos] = !bits_q[pos];
           end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) bits_q.push_back(1'($urandom));
    end else begin
      repeat ($urandom_range(0, 24)) bits_q.push_back(1'($urandom));
      want = ($urandom_range(0, 5) == 0) ? 24'hFF_FFFF : $urandom_range(0, 6);
    end
    set_want_count(want);
    fin = 1'b0;
    while (!fin) begin
      n = $urandom_range(0, 8);
      if (n >= bits_q.size()) begin
        n   = bits_q.size();
        fin = 1'b1;
      end
      // Unused low bits of the byte stay random.
      b = BYTE_W'($urandom);
      for (int j = 0; j < n; j++) b[BYTE_W-1-j] = bits_q.pop_front();
      if (n == 8 && $urandom_range(0, 7) == 0) n = $urandom_range(9, 15);
      send_data(b, n, fin);
      if (noisy && !fin && $urandom_range(0, 5) == 0) begin
        s = live_slot();
        send_node(tr_id[s],
                  $urandom_range(0, 2) == 0 ? -1 : tr_id[live_slot()],
                  $urandom_range(0, 2) == 0 ? -1 : tr_id[live_slot()],
                  $urandom_range(0, 1) == 0 ? -1 : int'($urandom_range(0, 255)));
        tree_dirty = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Root with two leaf children: every bit is a symbol, so a full final byte
  // gives the most results a request can cause. Also cover an oversized bit
  // count, an empty byte and a root rewrite in the middle of a stream.
  task automatic test_one_bit_codes();
    send_node(511, -1, 511, 255);
    send_node(5, 0, 0, 0);
    send_node(9, 5, 511, -1);
    send_node(0, 5, 511, -1);
    set_want_count(8);
    send_data(8'h5A, 8, 1'b1);   // eight symbols then ok
    set_want_count(12);
    send_data(8'hFF, 15, 1'b0);  // count above 8 reads the full byte
    send_data(8'h00, 0, 1'b0);   // no bits, no result
    send_node(0, 5, 9, -1);      // right branch now goes through node 9
    send_data(8'hC0, 3, 1'b1);   // two more symbols, ten of twelve: too few
  endtask

  // Zero expected symbols: an empty stream is fine, any symbol is too many
  // and the failure mutes the rest of the stream.
  task automatic test_zero_count();
    set_want_count(0);
    send_data(8'h00, 0, 1'b1);
    send_data(8'h00, 2, 1'b0);
    send_data(8'hFF, 8, 1'b1);
  endtask

  // Missing child: the failure holds through later bytes, and a stream that
  // stops mid-code at the largest count reports too few.
  task automatic test_invalid_code();
    set_want_count(24'hFF_FFFF);
    send_node(9, -1, 511, -1);
    send_data(8'h80, 2, 1'b1);
    send_data(8'h20, 4, 1'b0);
    send_data(8'hFF, 9, 1'b1);
    send_data(8'h40, 2, 1'b1);
  endtask

  // Random trees and streams under one idle profile.
  task automatic test_random_streams(input int gap, input int stall, input int items);
    int stop_at;
    // Pause the sender until every owed result is back before switching.
    wait_idle();
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = requests_sent + items;
    while (requests_sent < stop_at) begin
      if (tree_dirty || $urandom_range(0, 3) == 0) load_code_tree($urandom_range(2, 12));
      send_stream($urandom_range(0, 9) < 3);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_one_bit_codes();
    test_zero_count();
    test_invalid_code();
    tree_dirty = 1'b1;
    test_random_streams(28, 76, 105);
    test_random_streams(76, 28, 105);
    test_random_streams(0, 0, 100);

    wait_idle();
    $display("summary: %0d requests, %0d results checked, %0d symbols decoded",
             requests_sent, results_seen, symbols_seen);
    $display("summary: stream status ok %0d, invalid %0d, too many %0d, too few %0d",
             status_tally[ST_OK], status_tally[ST_BAD_CODE],
             status_tally[ST_TOO_MANY], status_tally[ST_TOO_FEW]);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: huffman_trie_decoder_unit.f
rtl/hufd_pkg.sv
rtl/hufd_node_mem.sv
rtl/huffman_trie_decoder_unit.sv
tb/sv/tb.sv
